// ===== hw/rtl/mts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_pkg: shared types and constants for the max tracking stack
// Stack size, derived widths, command, status and state codes.
// ----------------------------------------------------------------------------
package mts_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
	localparam int DATA_W      = 32;
	localparam int CMD_W       = 2;
	localparam int STATUS_W    = 2;
	// one RAM line holds {running max, value}
	localparam int LINE_W      = 2 * DATA_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH = 2'd0,
		CMD_POP  = 2'd1,
		CMD_MAX  = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		logic req_ready;
		logic ram_re;
		logic commit;
	} ctrl_t;

endpackage

// ===== hw/rtl/mts_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_req_if: request channel of the max tracking stack
// valid/ready handshake carrying one command word.
// ----------------------------------------------------------------------------
interface mts_req_if;
	logic                                valid;
	logic                                ready;
	logic [mts_pkg::CMD_W-1:0]           cmd;
	logic signed [mts_pkg::DATA_W-1:0]   push_value;

	modport source(output valid, output cmd, output push_value, input ready);
	modport sink(input valid, input cmd, input push_value, output ready);
endinterface

// ===== hw/rtl/mts_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_rsp_if: response channel of the max tracking stack
// valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface mts_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [mts_pkg::DATA_W-1:0]   result_value;
	logic [mts_pkg::STATUS_W-1:0]        status;
	logic [mts_pkg::DEPTH_W-1:0]         depth_after;

	modport source(output valid, output result_value, output status,
		output depth_after, input ready);
	modport sink(input valid, input result_value, input status,
		input depth_after, output ready);
endinterface

// ===== hw/rtl/mts_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/max_tracking_stack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_tracking_stack: LIFO stack of signed words with O(1) maximum query
// Each level in RAM holds the pushed value and the running max up to it.
// ----------------------------------------------------------------------------
// Usage:
//   req channel takes one command word: push (push_value), pop, or query max.
//   rsp channel returns exactly one word per command: result_value (popped
//   value or current max, zero otherwise), status (ok, empty, full) and
//   depth_after (entries held once the command is done).
//   On accept the command is captured and the top level read; the execute
//   state then loads the output register. No new command is taken until
//   the execute state is left, since the registered RAM read and the stack
//   pointer update that the next command depends on must finish first.
//   The response sits in an output register, so a new command is accepted
//   while the previous response still waits. If the receiver stalls, the
//   block holds the finished command in the execute state (nothing is
//   written, pointer unchanged) until the output register frees up.
//   Reset clears the pointer and the handshake state only; the RAM is not
//   cleared since a level's data is never used before it has been written.
//   Pop or max on an empty stack returns status empty; push on a full stack
//   is dropped with status full; command code three is a no-op with status ok.
// ----------------------------------------------------------------------------
module max_tracking_stack (
	input  logic          clk,
	input  logic          arst_n,
	mts_req_if.sink       req,
	mts_rsp_if.source     rsp
);

	// control
	mts_pkg::state_t                state_q, state_d;
	mts_pkg::ctrl_t                 ctrl;
	logic [mts_pkg::DEPTH_W-1:0]    count_q;
	logic [mts_pkg::DEPTH_W-1:0]    count_m1;
	logic                           rsp_free;

	// captured command
	mts_pkg::cmd_t                  cmd_q;
	logic signed [mts_pkg::DATA_W-1:0] val_q;

	// RAM
	logic                           ram_we;
	logic [mts_pkg::LINE_W-1:0]     ram_wdata;
	logic [mts_pkg::LINE_W-1:0]     ram_rdata;
	logic signed [mts_pkg::DATA_W-1:0] rd_val;
	logic signed [mts_pkg::DATA_W-1:0] rd_max;

	// execute stage results
	logic                           empty;
	logic                           full;
	logic signed [mts_pkg::DATA_W-1:0] new_max;
	logic signed [mts_pkg::DATA_W-1:0] res_value;
	mts_pkg::status_t               res_status;
	logic [mts_pkg::DEPTH_W-1:0]    res_count;

	// output register
	logic                           rsp_valid_q;
	logic signed [mts_pkg::DATA_W-1:0] rsp_value_q;
	logic [mts_pkg::STATUS_W-1:0]   rsp_status_q;
	logic [mts_pkg::DEPTH_W-1:0]    rsp_depth_q;

	assign rsp_free = !rsp_valid_q || rsp.ready;
	assign count_m1 = count_q - mts_pkg::DEPTH_W'(1);

	// --- sequencer ----------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mts_pkg::S_IDLE: begin
				if (req.valid) state_d = mts_pkg::S_EXEC;
			end
			mts_pkg::S_EXEC: begin
				if (rsp_free) state_d = mts_pkg::S_IDLE;
			end
			default: state_d = mts_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		unique case (state_q)
			mts_pkg::S_IDLE: begin
				ctrl.req_ready = 1'b1;
				ctrl.ram_re    = req.valid;
			end
			mts_pkg::S_EXEC: begin
				// commit only when the result can land in the output register
				ctrl.commit = rsp_free;
			end
			default: ctrl = '0;
		endcase
	end

	assign req.ready = ctrl.req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mts_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// capture the command on accept
	always_ff @(posedge clk) begin
		if (req.valid && ctrl.req_ready) begin
			cmd_q <= mts_pkg::cmd_t'(req.cmd);
			val_q <= req.push_value;
		end
	end

	// --- stack RAM: {running max, value} per level -------------------------
	// Every command reads level count-1 in the accept cycle; read data stays
	// put during a stall since re only fires on accept.
	mts_ram #(
		.WIDTH(mts_pkg::LINE_W),
		.DEPTH(mts_pkg::STACK_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[mts_pkg::ADDR_W-1:0]),
		.wdata (ram_wdata),
		.re    (ctrl.ram_re),
		.raddr (count_m1[mts_pkg::ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	assign rd_val = ram_rdata[mts_pkg::DATA_W-1:0];
	assign rd_max = ram_rdata[mts_pkg::LINE_W-1:mts_pkg::DATA_W];

	// --- execute ------------------------------------------------------------
	assign empty = (count_q == '0);
	assign full  = (count_q == mts_pkg::DEPTH_W'(mts_pkg::STACK_DEPTH));

	// bottom level's max is its own value
	assign new_max   = (!empty && (rd_max > val_q)) ? rd_max : val_q;
	assign ram_wdata = {new_max, val_q};

	always_comb begin
		res_value  = '0;
		res_status = mts_pkg::ST_OK;
		res_count  = count_q;
		ram_we     = 1'b0;
		case (cmd_q)
			mts_pkg::CMD_PUSH: begin
				if (full) begin
					res_status = mts_pkg::ST_FULL;
				end else begin
					ram_we    = ctrl.commit;
					res_count = count_q + mts_pkg::DEPTH_W'(1);
				end
			end
			mts_pkg::CMD_POP: begin
				if (empty) begin
					res_status = mts_pkg::ST_EMPTY;
				end else begin
					res_value = rd_val;
					res_count = count_m1;
				end
			end
			mts_pkg::CMD_MAX: begin
				if (empty) begin
					res_status = mts_pkg::ST_EMPTY;
				end else begin
					res_value = rd_max;
				end
			end
			default: begin
				// unused code: no-op
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.commit) begin
			count_q <= res_count;
		end
	end

	// --- output register ----------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctrl.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.commit) begin
			rsp_value_q  <= res_value;
			rsp_status_q <= res_status;
			rsp_depth_q  <= res_count;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.result_value = rsp_value_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.depth_after  = rsp_depth_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= mts_pkg::DEPTH_W'(mts_pkg::STACK_DEPTH))
		else $error("stack pointer beyond depth");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == mts_pkg::S_EXEC))
		else $error("accepted command not executed");

	a_depth_match: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.depth_after == count_q))
		else $error("reported depth differs from stack pointer");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> (count_q == $past(count_q) + mts_pkg::DEPTH_W'(1)))
		else $error("push did not advance stack pointer");
`endif

endmodule
